FILE: src/fopa_pkg.sv
// Shared types and codes for the fixed object pool allocator.
// No dependencies; compiled first.

package fopa_pkg;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_GET  = 2'd1,
		CMD_PUT  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_SMALL    = 3'd2,
		ST_BADADDR  = 3'd3,
		ST_NOTREADY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_POOL_BYTES    = 2'd0,
		CFG_SLOT_BYTES    = 2'd1,
		CFG_VIRTUAL_BASE  = 2'd2,
		CFG_PHYSICAL_BASE = 2'd3
	} cfg_idx_t;

	localparam int SLOT_BYTES_W  = 16;
	localparam int POOL_BYTES_W  = 32;
	localparam int ADDR_W        = 64;
	localparam int MIN_SLOT_BYTES = 8;

endpackage

FILE: src/fopa_cmd_if.sv
// Command channel: one item per allocator request.
// Uses no package; payload widths are fixed.

interface fopa_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] object_address;

	modport source (output valid, command, object_address, input ready);
	modport sink (input valid, command, object_address, output ready);
endinterface

FILE: src/fopa_rsp_if.sv
// Response channel: one result item per accepted command.
// Uses no package; payload widths are fixed.

interface fopa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] granted_address;
	logic [63:0] granted_physical;

	modport source (output valid, status, granted_address, granted_physical, input ready);
	modport sink (input valid, status, granted_address, granted_physical, output ready);
endinterface

FILE: src/fopa_cfg_if.sv
// Configuration write channel: register index and write data.
// Uses no package; payload widths are fixed.

interface fopa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/fixed_object_pool_allocator.sv
// Fixed-size object pool allocator with a LIFO free list of slot links.
// Depends on fopa_pkg and the fopa_cmd_if, fopa_rsp_if, fopa_cfg_if interfaces.
// Timing: one command at a time. A get passes through S_GET_LINK and S_RESP; an unknown
// command or an early error goes straight to S_RESP, and a put whose offset is out of
// range goes through S_PUT_CHK to S_RESP. A put that passes the range check runs one
// restoring-division step per cycle through the shared divider, DIV_W steps (32 while
// MAX_SLOTS is below 65536, else SLOT_W + 16), then S_DIV_END and S_RESP. An init uses
// the same divider for the slot count, then writes one link per cycle into link memory.
// The command port is ready again as soon as the result sits in the output register.

module fixed_object_pool_allocator #(
	parameter int MAX_SLOTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	fopa_cmd_if.sink        cmd,
	fopa_rsp_if.source      rsp,
	fopa_cfg_if.sink        cfg
);
	import fopa_pkg::*;

	localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int LIM_W  = SLOT_W + SLOT_BYTES_W;
	localparam int DIV_W  = (LIM_W > POOL_BYTES_W) ? LIM_W : POOL_BYTES_W;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam logic [SLOT_W-1:0] END_MARK = SLOT_W'(MAX_SLOTS);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DIV      = 7'b0000010,
		S_DIV_END  = 7'b0000100,
		S_WALK     = 7'b0001000,
		S_PUT_CHK  = 7'b0010000,
		S_GET_LINK = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t state_q;
	cmd_t   op_q;
	status_t res_status_q;

	// configuration registers
	logic [POOL_BYTES_W-1:0] pool_bytes_q;
	logic [SLOT_BYTES_W-1:0] slot_bytes_q;
	logic [ADDR_W-1:0]       virtual_base_q;
	logic [ADDR_W-1:0]       physical_base_q;

	// free list state
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] slot_total_q;
	logic              ready_q;
	logic [SLOT_W-1:0] walk_q;

	// shared divider and datapath
	logic [DIV_W-1:0]        div_q;
	logic [SLOT_BYTES_W:0]   rem_q;
	logic [SLOT_BYTES_W-1:0] den_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [LIM_W-1:0]        prod_q;
	logic [ADDR_W-1:0]       off_q;

	logic [SLOT_BYTES_W:0] rem_sh;
	logic                  rem_ge;
	logic [SLOT_BYTES_W:0] rem_nx;
	logic [SLOT_W-1:0]     mul_a;
	logic [SLOT_W-1:0]     walk_nx;
	logic [SLOT_W-1:0]     count_sat;

	// link memory
	logic [SLOT_W-1:0] link_mem [MAX_SLOTS];
	logic [SLOT_W-1:0] link_rd_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [SLOT_W-1:0] mem_wd;

	// output register
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [ADDR_W-1:0] rsp_va_q;
	logic [ADDR_W-1:0] rsp_pa_q;

	logic cmd_acc;
	logic rsp_free;
	cmd_t cmd_op;

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd_op    = cmd_t'(cmd.command);
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.granted_address  = rsp_va_q;
	assign rsp.granted_physical = rsp_pa_q;

	// one restoring-division step
	assign rem_sh = {rem_q[SLOT_BYTES_W-1:0], div_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

	assign mul_a   = (cmd_op == CMD_GET) ? head_q : slot_total_q;
	assign walk_nx = walk_q + SLOT_W'(1);
	assign count_sat = (div_q >= DIV_W'(MAX_SLOTS)) ? END_MARK : SLOT_W'(div_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = walk_q[IDX_W-1:0];
		mem_wd = (walk_nx == slot_total_q) ? END_MARK : walk_nx;
		unique case (state_q)
			S_WALK: begin
				mem_we = 1'b1;
			end
			S_DIV_END: begin
				// push the returned slot when the division left no remainder
				mem_we = (op_q == CMD_PUT) && (rem_q == '0);
				mem_wa = div_q[IDX_W-1:0];
				mem_wd = head_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		link_rd_q <= link_mem[head_q[IDX_W-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_bytes_q    <= '0;
			slot_bytes_q    <= SLOT_BYTES_W'(MIN_SLOT_BYTES);
			virtual_base_q  <= '0;
			physical_base_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_POOL_BYTES:    pool_bytes_q    <= cfg.data[POOL_BYTES_W-1:0];
				CFG_SLOT_BYTES:    slot_bytes_q    <= cfg.data[SLOT_BYTES_W-1:0];
				CFG_VIRTUAL_BASE:  virtual_base_q  <= cfg.data;
				CFG_PHYSICAL_BASE: physical_base_q <= cfg.data;
				default:           pool_bytes_q    <= pool_bytes_q;
			endcase
		end
	end

	// output register handshake: load from S_RESP, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= CMD_INIT;
			res_status_q <= ST_OK;
			head_q       <= END_MARK;
			slot_total_q <= '0;
			ready_q      <= 1'b0;
			walk_q       <= '0;
			cnt_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						op_q         <= cmd_op;
						res_status_q <= ST_OK;
						state_q      <= S_RESP;
						cnt_q        <= CNT_W'(DIV_W);
						case (cmd_op)
							CMD_INIT: begin
								if (slot_bytes_q < SLOT_BYTES_W'(MIN_SLOT_BYTES)) begin
									res_status_q <= ST_SMALL;
									ready_q      <= 1'b0;
								end else begin
									state_q <= S_DIV;
								end
							end
							CMD_GET: begin
								if (!ready_q) begin
									res_status_q <= ST_NOTREADY;
								end else if (head_q == END_MARK) begin
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_GET_LINK;
								end
							end
							CMD_PUT: begin
								if (!ready_q) begin
									res_status_q <= ST_NOTREADY;
								end else if (slot_bytes_q == '0) begin
									res_status_q <= ST_BADADDR;
								end else begin
									state_q <= S_PUT_CHK;
								end
							end
							default: begin
								res_status_q <= ST_OK;
							end
						endcase
					end
				end
				S_PUT_CHK: begin
					if (off_q >= ADDR_W'(prod_q)) begin
						res_status_q <= ST_BADADDR;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					state_q <= S_RESP;
					if (op_q == CMD_INIT) begin
						slot_total_q <= count_sat;
						ready_q      <= 1'b1;
						walk_q       <= '0;
						if (count_sat == '0) begin
							head_q <= END_MARK;
						end else begin
							head_q  <= '0;
							state_q <= S_WALK;
						end
					end else if (rem_q != '0) begin
						res_status_q <= ST_BADADDR;
					end else begin
						head_q <= SLOT_W'(div_q[IDX_W-1:0]);
					end
				end
				S_WALK: begin
					walk_q <= walk_nx;
					if (walk_nx == slot_total_q) begin
						state_q <= S_RESP;
					end
				end
				S_GET_LINK: begin
					// pop: the link of the old head becomes the new head
					head_q  <= link_rd_q;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			prod_q <= LIM_W'(mul_a) * LIM_W'(slot_bytes_q);
			off_q  <= cmd.object_address - virtual_base_q;
			den_q  <= slot_bytes_q;
			rem_q  <= '0;
			div_q  <= DIV_W'(pool_bytes_q);
		end else if (state_q == S_PUT_CHK) begin
			div_q <= off_q[DIV_W-1:0];
		end else if (state_q == S_DIV) begin
			rem_q <= rem_nx;
			div_q <= {div_q[DIV_W-2:0], rem_ge};
		end
		if (state_q == S_RESP && rsp_free) begin
			rsp_status_q <= res_status_q;
			if (op_q == CMD_GET && res_status_q == ST_OK) begin
				rsp_va_q <= virtual_base_q + ADDR_W'(prod_q);
				rsp_pa_q <= physical_base_q + ADDR_W'(prod_q);
			end else begin
				rsp_va_q <= '0;
				rsp_pa_q <= '0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command port ready right after an accepted item");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q && head_q != END_MARK |-> head_q < slot_total_q)
		else $error("free list head outside the slot range");

	a_error_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != ST_OK |-> rsp_va_q == '0 && rsp_pa_q == '0)
		else $error("address returned with an error status");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != '0)
		else $error("divider running with a zero slot size");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> walk_q < slot_total_q)
		else $error("init walk beyond the slot count");

endmodule
